// ===== hdl/bounded_array_list_engine_unit_defines.svh =====
// Assertion macros shared by the array list engine.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bale_pkg.sv =====
// Package for the array list engine: field widths, operation and status codes,
// sequencer states and the result record. No dependencies.
`timescale 1ns / 1ps

package bale_pkg;

    localparam int MODE_W     = 3;
    localparam int POS_W      = 8;
    localparam int COORD_W    = 32;
    localparam int POINT_W    = 3 * COORD_W;
    localparam int STATUS_W   = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int CAP_W      = 9;

    localparam int MAX_ITEMS_DEFAULT = 256;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_SET    = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COORD_W-1:0]     read_x;
        logic [COORD_W-1:0]     read_y;
        logic [COORD_W-1:0]     read_z;
        logic [COUNT_OUT_W-1:0] entry_count;
    } res_t;

endpackage

// ===== hdl/bale_if.sv =====
// Handshake channel interfaces of the array list engine: command, result and
// configuration write. Depends on bale_pkg for field widths.
`timescale 1ns / 1ps

interface bale_cmd_if
    import bale_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [POS_W-1:0]     position;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;

    modport source (output valid, mode, position, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, mode, position, coord_x, coord_y, coord_z, output ready);
endinterface

interface bale_rsp_if
    import bale_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [COORD_W-1:0]     read_x;
    logic [COORD_W-1:0]     read_y;
    logic [COORD_W-1:0]     read_z;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, status, read_x, read_y, read_z, entry_count, input ready);
    modport sink   (input valid, status, read_x, read_y, read_z, entry_count, output ready);
endinterface

interface bale_cfg_if
    import bale_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/bale_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module bale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/bale_seq.sv =====
// Operation sequencer of the array list engine: decodes one command, runs the
// read-modify-write shift through the point RAM and builds the result. Uses bale_pkg.
`timescale 1ns / 1ps

module bale_seq
    import bale_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bale_cmd_if.sink                         cmd,
    input  logic [CAP_W-1:0]                 cap,
    output logic                             res_valid,
    input  logic                             res_take,
    output res_t                             res,
    output logic [$clog2(MAX_ITEMS+1)-1:0]   fill
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_ITEMS);

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POINT_W-1:0]  pt_reg, pt_next;
    logic [POINT_W-1:0]  rpt_reg, rpt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       wptr_reg, wptr_next;
    logic                pend_reg, pend_next;

    logic                we, re;
    logic [AW-1:0]       waddr, raddr;
    logic [POINT_W-1:0]  wdata, rdata;

    logic [LW-1:0] count_l, pos_l, cap_l, cap_eff;
    logic [LW-1:0] pos_inc_l, count_dec_l, ins_moves_l, rem_moves_l;
    logic          full, pos_ok, is_insert;

    assign count_l     = LW'(count_reg);
    assign pos_l       = LW'(pos_reg);
    assign cap_l       = LW'(cap);
    assign cap_eff     = (cap_l > MAX_L) ? MAX_L : cap_l;
    assign full        = (count_l >= cap_eff);
    assign pos_ok      = (pos_l < count_l);
    assign pos_inc_l   = pos_l + LW'(1);
    assign count_dec_l = count_l - LW'(1);
    assign ins_moves_l = count_l - pos_l;
    assign rem_moves_l = count_dec_l - pos_l;
    assign is_insert   = (mode_reg == MODE_INSERT);

    bale_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (mode_reg == MODE_INSERT && !full && pos_ok)
                begin
                    state_next = S_SHIFT;
                end
                else if (mode_reg == MODE_REMOVE && pos_ok)
                begin
                    state_next = S_SHIFT;
                end
                else if (mode_reg == MODE_GET && pos_ok)
                begin
                    state_next = S_READ_WAIT;
                end
            end
            S_SHIFT:
            begin
                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shift hazards cannot occur: the read runs two entries ahead of the write, in
    // the direction away from it, so no cycle reads and writes the same entry.
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pt_next     = pt_reg;
        rpt_next    = rpt_reg;
        status_next = status_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        wptr_next   = wptr_reg;
        pend_next   = pend_reg;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = wptr_reg;
        wdata       = rdata;
        raddr       = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next = cmd.mode;
                    pos_next  = cmd.position;
                    pt_next   = {cmd.coord_x, cmd.coord_y, cmd.coord_z};
                end
            end
            S_DECIDE:
            begin
                status_next = ST_OK;
                rpt_next    = '0;
                pend_next   = 1'b0;
                unique case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = count_l[AW-1:0];
                            wdata      = pt_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (!pos_ok)
                        begin
                            status_next = ST_NO_INDEX;
                        end
                        else
                        begin
                            idx_next = count_dec_l[AW-1:0];
                            rem_next = ins_moves_l[CW-1:0];
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = ST_NO_INDEX;
                        end
                        else
                        begin
                            idx_next = pos_inc_l[AW-1:0];
                            rem_next = rem_moves_l[CW-1:0];
                        end
                    end
                    MODE_GET:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = ST_NO_INDEX;
                        end
                        else
                        begin
                            re    = 1'b1;
                            raddr = pos_l[AW-1:0];
                        end
                    end
                    MODE_SET:
                    begin
                        if (!pos_ok)
                        begin
                            status_next = ST_NO_INDEX;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = pos_l[AW-1:0];
                            wdata = pt_reg;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = wptr_reg;
                    wdata = rdata;
                end
                if (rem_reg != '0)
                begin
                    re        = 1'b1;
                    raddr     = idx_reg;
                    rem_next  = rem_reg - CW'(1);
                    pend_next = 1'b1;
                    if (is_insert)
                    begin
                        idx_next  = idx_reg - AW'(1);
                        wptr_next = idx_reg + AW'(1);
                    end
                    else
                    begin
                        idx_next  = idx_reg + AW'(1);
                        wptr_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (is_insert)
                        begin
                            we         = 1'b1;
                            waddr      = pos_l[AW-1:0];
                            wdata      = pt_reg;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
            end
            S_READ_WAIT:
            begin
                rpt_next = rdata;
            end
            S_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign fill      = count_reg;

    always_comb
    begin
        res.status      = status_reg;
        res.read_x      = rpt_reg[POINT_W-1 -: COORD_W];
        res.read_y      = rpt_reg[COORD_W +: COORD_W];
        res.read_z      = rpt_reg[0 +: COORD_W];
        res.entry_count = count_l[COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        pt_reg     <= pt_next;
        rpt_reg    <= rpt_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        wptr_reg   <= wptr_next;
    end

endmodule

// ===== hdl/bounded_array_list_engine_unit.sv =====
// Top level of the array list engine: capacity register, result output register
// and assertions. Uses bale_pkg, the bale interfaces, bale_seq and the defines header.
//
//  channel | role   | handshake   | carries
//  --------+--------+-------------+------------------------------------------------
//  cmd     | sink   | valid/ready | mode, position, coord_x, coord_y, coord_z
//  rsp     | source | valid/ready | status, read_x, read_y, read_z, entry_count
//  cfg     | sink   | valid/ready | data (capacity_limit, always ready)
//
// One item is in work at a time. An accepted item passes from idle to a decide
// state; if not refused, insert and remove run a shift state that moves the
// entries one by one (removing the last entry moves none), get waits in a read wait
// state, and all else goes to done; the result is loaded before the next is taken.
// Reset clears the list count and sets the capacity to 256; stored points are kept.
// A stalled result waits in the output register; the input stalls at the next one.
`timescale 1ns / 1ps
`include "bounded_array_list_engine_unit_defines.svh"

module bounded_array_list_engine_unit
    import bale_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bale_cmd_if.sink   cmd,
    bale_rsp_if.source rsp,
    bale_cfg_if.sink   cfg
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_ITEMS);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg, out_res_next;

    logic                   res_valid, res_take, load;
    res_t                   res;
    logic [CW-1:0]          fill;
    logic [LW-1:0]          fill_l;
    logic [COUNT_OUT_W-1:0] fill_out;

    bale_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cap       (cap_reg),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .fill      (fill)
    );

    assign fill_l   = LW'(fill);
    assign fill_out = fill_l[COUNT_OUT_W-1:0];

    // Always ready; the user sends writes only while idle, which is not enforced.
    assign cfg.ready = 1'b1;
    assign cap_next  = (cfg.valid) ? cfg.data : cap_reg;

    // The output register accepts a new result whenever it is empty or being drained.
    assign res_take = !out_valid_reg || rsp.ready;
    assign load     = res_valid && res_take;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.read_x      = out_res_reg.read_x;
    assign rsp.read_y      = out_res_reg.read_y;
    assign rsp.read_z      = out_res_reg.read_z;
    assign rsp.entry_count = out_res_reg.entry_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // The list never holds more entries than the store has rows.
    `BALE_ASSERT_NOW(a_fill_bound, 1'b1, fill_l <= MAX_L, "entry count exceeds store depth")
    // Only one item is in the sequencer at a time.
    `BALE_ASSERT_NEXT(a_one_item, cmd.valid && cmd.ready, !cmd.ready, "item accepted while busy")
    // A finished result that waits for the output register blocks new items.
    `BALE_ASSERT_NOW(a_hold_input, res_valid, !cmd.ready, "item accepted with result pending")
    // A loaded result carries the count left by its own operation.
    `BALE_ASSERT_NEXT(a_count_match, load, rsp.valid && rsp.entry_count == $past(fill_out),
        "result count mismatch")

endmodule

// ===== verif/tb_bounded_array_list_engine_unit.sv =====
// Self-checking testbench for bounded_array_list_engine_unit: drives list commands and
// capacity writes, predicts each result in-bench and compares every result item.
// Depends on bale_pkg, the bale channel interfaces and the engine RTL.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine_unit;
    import bale_pkg::*;

    // The engine is built at its default depth, so the list holds at most 256 points.
    localparam int LIST_DEPTH = MAX_ITEMS_DEFAULT;

    // Modes six and seven are not operations; the engine must ignore them.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    // Two copies of the list state are kept. The planning copy runs ahead while
    // stimulus is queued, so that positions can be aimed at entries that exist.
    // The checking copy is advanced only when the engine accepts an item.
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    // The longest correct quiet stretch is the forced receiver hold plus one full
    // shift of the list; the watchdog allows several times that.
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   position;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } list_cmd_t;

    logic clk;
    logic rst_n;

    bale_cmd_if cmd_ch ();
    bale_rsp_if rsp_ch ();
    bale_cfg_if cfg_ch ();

    bounded_array_list_engine_unit #(
        .MAX_ITEMS(LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Mirror of the point store and of the list bookkeeping, one per copy.
    logic [COORD_W-1:0] pt_x [2][LIST_DEPTH];
    logic [COORD_W-1:0] pt_y [2][LIST_DEPTH];
    logic [COORD_W-1:0] pt_z [2][LIST_DEPTH];
    int                 list_fill [2] = '{0, 0};
    logic [CAP_W-1:0]   list_cap  [2] = '{CAP_RESET, CAP_RESET};

    list_cmd_t cmd_backlog[$];      // commands waiting to be offered to the engine
    res_t      pending_results[$];  // predicted results, oldest first

    int error_count = 0;
    int idle_cycles = 0;

    // Idle rates in percent for the sender and the receiver.
    int send_idle_pct = 24;
    int recv_idle_pct = 24;

    // A long receiver hold is requested by the stimulus and timed by the receiver.
    int hold_requests_made   = 0;
    int hold_requests_served = 0;
    int hold_left            = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void store_point(int c, int idx, list_cmd_t op);
        pt_x[c][idx] = op.coord_x;
        pt_y[c][idx] = op.coord_y;
        pt_z[c][idx] = op.coord_z;
    endfunction

    // Performs one list command on the chosen copy and returns the result item
    // that the engine must produce for it.
    function automatic res_t apply_list_op(int c, list_cmd_t op);
        res_t r;
        int   limit;
        int   n;
        int   p;
        r        = '0;
        r.status = ST_OK;
        // A capacity above the store depth saturates at the depth.
        limit = (int'(list_cap[c]) > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap[c]);
        n     = list_fill[c];
        p     = int'(op.position);
        case (op.mode)
            MODE_APPEND:
            begin
                if (n >= limit)
                    r.status = ST_FULL;
                else
                begin
                    store_point(c, n, op);
                    n++;
                end
            end
            MODE_INSERT:
            begin
                // Full wins over a bad index; insert never appends at the end.
                if (n >= limit)
                    r.status = ST_FULL;
                else if (p >= n)
                    r.status = ST_NO_INDEX;
                else
                begin
                    for (int i = n; i > p; i--)
                    begin
                        pt_x[c][i] = pt_x[c][i-1];
                        pt_y[c][i] = pt_y[c][i-1];
                        pt_z[c][i] = pt_z[c][i-1];
                    end
                    store_point(c, p, op);
                    n++;
                end
            end
            MODE_REMOVE:
            begin
                if (p >= n)
                    r.status = ST_NO_INDEX;
                else
                begin
                    for (int i = p; i + 1 < n; i++)
                    begin
                        pt_x[c][i] = pt_x[c][i+1];
                        pt_y[c][i] = pt_y[c][i+1];
                        pt_z[c][i] = pt_z[c][i+1];
                    end
                    n--;
                end
            end
            MODE_GET:
            begin
                if (p >= n)
                    r.status = ST_NO_INDEX;
                else
                begin
                    r.read_x = pt_x[c][p];
                    r.read_y = pt_y[c][p];
                    r.read_z = pt_z[c][p];
                end
            end
            MODE_SET:
            begin
                if (p >= n)
                    r.status = ST_NO_INDEX;
                else
                    store_point(c, p, op);
            end
            MODE_CLEAR:
            begin
                // Only the count is dropped; the stored words stay where they are.
                n = 0;
            end
            default:
            begin
            end
        endcase
        list_fill[c]  = n;
        r.entry_count = n[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Queues one command and advances the planning copy past it.
    task automatic queue_cmd(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
        list_cmd_t op;
        op.mode     = mode;
        op.position = pos;
        op.coord_x  = x;
        op.coord_y  = y;
        op.coord_z  = z;
        void'(apply_list_op(PLAN, op));
        cmd_backlog.insert(cmd_backlog.size(), op);
    endtask

    // Random commands with random points. Most positions name an entry that
    // exists, so that shifts and reads really happen; a few are out of range and
    // a few items are pure noise, spare modes included. grow_pct sets how often
    // the list is asked to grow. Ignored items do not count toward how_many.
    task automatic queue_random_items(int how_many, int grow_pct);
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        int                n;
        int                made;
        int                sub;
        made = 0;
        while (made < how_many)
        begin
            n   = list_fill[PLAN];
            pos = POS_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 4)
                mode = MODE_W'($urandom_range(0, 7));
            else
            begin
                sub = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < grow_pct)
                    mode = (sub < 35) ? MODE_INSERT : MODE_APPEND;
                else if (sub < 40)
                    mode = MODE_REMOVE;
                else if (sub < 70)
                    mode = MODE_GET;
                else if (sub < 97)
                    mode = MODE_SET;
                else
                    mode = MODE_CLEAR;
                if (n != 0 && $urandom_range(0, 9) != 0)
                    pos = POS_W'($urandom_range(0, n - 1));
            end
            queue_cmd(mode, pos, $urandom(), $urandom(), $urandom());
            if (mode != MODE_SPARE_A && mode != MODE_SPARE_B)
                made++;
        end
    endtask

    // Returns on a clock edge once every queued command has been accepted and
    // every predicted result has come back, plus a short settling pause. The
    // check runs on the falling edge, after the driver and scoreboard have settled.
    task automatic wait_for_drain();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes the capacity register and waits for the write to be taken. The
    // checking copy picks the new value up from the handshake itself.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid   <= 1'b0;
        list_cap[PLAN] = value;
    endtask

    // Command driver: a new item is offered only when the previous one has been
    // taken or none was offered, and then skipped at random to leave gaps.
    always @(posedge clk)
    begin : cmd_driver
        list_cmd_t next_cmd;
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd         = cmd_backlog.pop_front();
                cmd_ch.mode     <= next_cmd.mode;
                cmd_ch.position <= next_cmd.position;
                cmd_ch.coord_x  <= next_cmd.coord_x;
                cmd_ch.coord_y  <= next_cmd.coord_y;
                cmd_ch.coord_z  <= next_cmd.coord_z;
                cmd_ch.valid    <= 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random back-pressure, or a long hold when one is requested.
    always @(posedge clk)
    begin : rsp_sink
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_requests_served != hold_requests_made)
        begin
            rsp_ch.ready         <= 1'b0;
            hold_left            <= HOLD_CYCLES;
            hold_requests_served <= hold_requests_served + 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Scoreboard: results are checked against the oldest prediction; each
    // accepted command is run through the checking copy to make a new one.
    always @(posedge clk)
    begin : scoreboard
        res_t      got;
        res_t      want;
        list_cmd_t seen;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status      = rsp_ch.status;
                got.read_x      = rsp_ch.read_x;
                got.read_y      = rsp_ch.read_y;
                got.read_z      = rsp_ch.read_z;
                got.entry_count = rsp_ch.entry_count;
                if (pending_results.size() == 0)
                    report_mismatch("result with none expected, status", got.status, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.read_x != want.read_x)
                        report_mismatch("read_x", got.read_x, want.read_x);
                    if (got.read_y != want.read_y)
                        report_mismatch("read_y", got.read_y, want.read_y);
                    if (got.read_z != want.read_z)
                        report_mismatch("read_z", got.read_z, want.read_z);
                    if (got.entry_count != want.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.entry_count);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.mode     = cmd_ch.mode;
                seen.position = cmd_ch.position;
                seen.coord_x  = cmd_ch.coord_x;
                seen.coord_y  = cmd_ch.coord_y;
                seen.coord_z  = cmd_ch.coord_z;
                pending_results.insert(pending_results.size(), apply_list_op(CHECK, seen));
            end
            if (cfg_ch.valid && cfg_ch.ready)
                list_cap[CHECK] = cfg_ch.data;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        // Every input of the engine starts at a known value.
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_APPEND;
        cmd_ch.position = '0;
        cmd_ch.coord_x  = '0;
        cmd_ch.coord_y  = '0;
        cmd_ch.coord_z  = '0;
        rsp_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity. The list starts empty, so every
        // indexed operation must report no such index, insert included.
        queue_cmd(MODE_GET,    8'd0, '0, '0, '0);
        queue_cmd(MODE_REMOVE, 8'd0, '0, '0, '0);
        queue_cmd(MODE_SET,    8'd0, '1, '1, '1);
        queue_cmd(MODE_INSERT, 8'd0, '1, '1, '1);
        // Three appends with all-ones, all-zeros and alternating patterns.
        queue_cmd(MODE_APPEND, 8'd0, '1, '1, '1);
        queue_cmd(MODE_APPEND, 8'd255, '0, '0, '0);
        queue_cmd(MODE_APPEND, 8'd0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        // Insert in the middle moves the tail up; insert at the count is refused.
        queue_cmd(MODE_INSERT, 8'd1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C);
        queue_cmd(MODE_INSERT, 8'd4, 32'h0BAD_F00D, 32'h0BAD_F00D, 32'h0BAD_F00D);
        queue_cmd(MODE_GET,    8'd255, '0, '0, '0);
        queue_cmd(MODE_GET,    8'd0, '0, '0, '0);
        queue_cmd(MODE_GET,    8'd1, '0, '0, '0);
        queue_cmd(MODE_GET,    8'd3, '0, '0, '0);
        queue_cmd(MODE_SET,    8'd2, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h8000_0001);
        // Remove the head, then the last entry, which needs no shift at all.
        queue_cmd(MODE_REMOVE, 8'd0, '0, '0, '0);
        queue_cmd(MODE_REMOVE, 8'd2, '0, '0, '0);
        // Spare modes with busy fields must leave the list alone.
        queue_cmd(MODE_SPARE_A, 8'd1, '1, '1, '1);
        queue_cmd(MODE_SPARE_B, 8'd0, '1, '1, '1);
        queue_cmd(MODE_GET,    8'd1, '0, '0, '0);
        wait_for_drain();

        // Capacity equal to the count: the list is full, and a full insert
        // reports full even with a position that does not exist.
        write_capacity(9'd2);
        queue_cmd(MODE_APPEND, 8'd0, '1, '0, '1);
        queue_cmd(MODE_INSERT, 8'd255, '1, '0, '1);
        queue_cmd(MODE_INSERT, 8'd0, '1, '0, '1);
        wait_for_drain();

        // Capacity zero: nothing can be added, but removal and clear still work.
        write_capacity(9'd0);
        queue_cmd(MODE_APPEND, 8'd0, '1, '1, '1);
        queue_cmd(MODE_REMOVE, 8'd1, '0, '0, '0);
        queue_cmd(MODE_CLEAR,  8'd0, '0, '0, '0);
        queue_cmd(MODE_GET,    8'd0, '0, '0, '0);
        wait_for_drain();

        // Capacity beyond the store saturates at its depth. The list is grown,
        // then topped off to the very last slot, while the receiver holds off
        // once for a long stretch so that the engine backs up into its input.
        write_capacity(9'd511);
        queue_random_items(320, 80);
        hold_requests_made++;
        while (list_fill[PLAN] < LIST_DEPTH)
            queue_cmd(MODE_APPEND, POS_W'($urandom_range(0, 255)),
                      $urandom(), $urandom(), $urandom());
        // Work at the top end of a completely full list.
        queue_cmd(MODE_APPEND, 8'd0, '1, '1, '1);
        queue_cmd(MODE_INSERT, 8'd0, '1, '1, '1);
        queue_cmd(MODE_GET,    8'd255, '0, '0, '0);
        queue_cmd(MODE_SET,    8'd255, 32'hFFFF_0000, 32'h0000_FFFF, 32'hF0F0_F0F0);
        queue_cmd(MODE_GET,    8'd255, '0, '0, '0);
        queue_cmd(MODE_REMOVE, 8'd255, '0, '0, '0);
        // With one slot free, insert at the head moves every other entry.
        queue_cmd(MODE_INSERT, 8'd0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        queue_cmd(MODE_GET,    8'd0, '0, '0, '0);
        queue_cmd(MODE_GET,    8'd255, '0, '0, '0);
        wait_for_drain();

        // Capacity one, far below the count: the list only shrinks until cleared.
        write_capacity(9'd1);
        queue_random_items(60, 30);
        wait_for_drain();

        // A small random capacity with both sides running flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(CAP_W'($urandom_range(2, 40)));
        queue_random_items(140, 50);
        wait_for_drain();
        send_idle_pct = 24;
        recv_idle_pct = 24;

        // Back to the reset capacity.
        write_capacity(CAP_RESET);
        queue_random_items(100, 50);
        wait_for_drain();

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bale_pkg.sv
hdl/bale_if.sv
hdl/bale_ram.sv
hdl/bale_seq.sv
hdl/bounded_array_list_engine_unit.sv
verif/tb_bounded_array_list_engine_unit.sv
